[hw/rtl/bvp_pkg.sv]
// Shared types and constants for the battery voltage to percent block.
// Holds the discharge curve, per-segment reciprocals and the register codes.
// No dependencies.
package bvp_pkg;

	localparam int NPOINTS = 11;
	localparam int NSEG = NPOINTS - 1;

	// Fixed-point shift used by the reciprocal multiply
	localparam int RECIP_SHIFT = 16;

	typedef logic [14:0] mv_t;
	typedef logic [6:0] pct_t;
	typedef logic [12:0] recip_t;
	// Offset into a segment; the widest span is 300 mV
	typedef logic [8:0] seg_d_t;
	// Whole-step quotient within a segment, 0..10
	typedef logic [3:0] step_t;

	// Register codes of the configuration port
	typedef enum logic [0:0] {
		CFG_LOW_THRESHOLD  = 1'b0,
		CFG_CRIT_THRESHOLD = 1'b1
	} cfg_idx_t;

	localparam pct_t LOW_THRESHOLD_RESET  = 7'd20;
	localparam pct_t CRIT_THRESHOLD_RESET = 7'd10;
	localparam pct_t PCT_FULL  = 7'd100;
	localparam pct_t PCT_EMPTY = 7'd0;

	// Discharge curve, top point first
	localparam mv_t CURVE_MV [0:NPOINTS-1] = '{
		15'd12800, 15'd12650, 15'd12500, 15'd12350, 15'd12200, 15'd12050,
		15'd11900, 15'd11750, 15'd11600, 15'd11400, 15'd11100
	};
	localparam pct_t CURVE_PCT [0:NPOINTS-1] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40, 7'd30, 7'd20, 7'd10, 7'd0
	};

	// ceil(2^16 * 10 / span) for each segment: spans of 150, 200 and 300 mV.
	// Error stays well under one step across each span, so the floor is exact.
	localparam recip_t SEG_RECIP [0:NSEG-1] = '{
		13'd4370, 13'd4370, 13'd4370, 13'd4370, 13'd4370,
		13'd4370, 13'd4370, 13'd4370, 13'd3277, 13'd2185
	};

	typedef struct packed {
		pct_t percent;
		logic charge_low;
		logic charge_critical;
	} result_t;

endpackage

[hw/rtl/bvp_interp.sv]
// Curve lookup and linear interpolation of one voltage into percent,
// plus the low and critical flag compares. Purely combinational.
// Depends on bvp_pkg.
module bvp_interp (
	input  bvp_pkg::mv_t    voltage_mv,
	input  bvp_pkg::pct_t   low_thr,
	input  bvp_pkg::pct_t   crit_thr,
	output bvp_pkg::result_t result
);
	import bvp_pkg::*;

	mv_t    seg_lo;
	pct_t   seg_pct;
	recip_t seg_recip;
	mv_t    offset;
	seg_d_t seg_d;
	logic [RECIP_SHIFT+5:0] prod;
	step_t  step;
	pct_t   pct;

	// Pick the segment that holds the voltage
	always_comb begin
		seg_lo    = CURVE_MV[NPOINTS-1];
		seg_pct   = PCT_EMPTY;
		seg_recip = SEG_RECIP[NSEG-1];
		for (int k = 0; k < NSEG; k++) begin
			if (voltage_mv <= CURVE_MV[k] && voltage_mv > CURVE_MV[k+1]) begin
				seg_lo    = CURVE_MV[k+1];
				seg_pct   = CURVE_PCT[k+1];
				seg_recip = SEG_RECIP[k];
			end
		end
	end

	// Scale the offset by 10/span through the reciprocal
	assign offset = voltage_mv - seg_lo;
	assign seg_d  = offset[$bits(seg_d_t)-1:0];
	assign prod   = ($bits(prod))'(seg_d) * ($bits(prod))'(seg_recip);
	assign step   = prod[RECIP_SHIFT +: $bits(step_t)];

	// Clamp at both ends of the curve
	always_comb begin
		priority if (voltage_mv >= CURVE_MV[0]) begin
			pct = PCT_FULL;
		end else if (voltage_mv <= CURVE_MV[NPOINTS-1]) begin
			pct = PCT_EMPTY;
		end else begin
			pct = seg_pct + pct_t'(step);
		end
	end

	assign result.percent         = pct;
	assign result.charge_low      = (pct <= low_thr);
	assign result.charge_critical = (pct <= crit_thr);

endmodule

[hw/rtl/battery_voltage_to_percent.sv]
// Top level of the battery voltage to percent converter.
// Depends on bvp_pkg and bvp_interp.
//
// Usage:
//   Input channel (in_valid, in_stall, voltage_mv) carries one voltage item
//   in millivolts. Output channel (out_valid, out_stall, percent,
//   charge_low, charge_critical) returns one result item per input item,
//   in order. The two thresholds must be written through cfg_we, cfg_index and
//   cfg_data only while no item is in flight; the block does not enforce this.
// Path: the item passes the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; the curve lookup,
//   reciprocal multiply and flag compares all sit between the two registers.
// Reset: both stages empty, thresholds return to 20 % and 10 %.
// Stall: when out_stall holds a waiting result, the input register keeps
//   its item and in_stall rises until the result register frees up; no
//   item is dropped or repeated.
module battery_voltage_to_percent (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bvp_pkg::mv_t      voltage_mv,
	output logic              out_valid,
	input  logic              out_stall,
	output bvp_pkg::pct_t     percent,
	output logic              charge_low,
	output logic              charge_critical,
	input  logic              cfg_we,
	input  bvp_pkg::cfg_idx_t cfg_index,
	input  bvp_pkg::pct_t     cfg_data
);
	import bvp_pkg::*;

	logic    valid_s1;
	mv_t     voltage_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t result_d;
	pct_t    low_thr_q;
	pct_t    crit_thr_q;
	logic    adv_out;
	logic    in_accept;

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= LOW_THRESHOLD_RESET;
			crit_thr_q <= CRIT_THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW_THRESHOLD:  low_thr_q  <= cfg_data;
				CFG_CRIT_THRESHOLD: crit_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance when the result register is empty or being drained
	assign adv_out   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_out;
	assign in_accept = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			voltage_s1 <= voltage_mv;
		end
	end

	bvp_interp u_interp (
		.voltage_mv (voltage_s1),
		.low_thr    (low_thr_q),
		.crit_thr   (crit_thr_q),
		.result     (result_d)
	);

	// Result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			result_q <= result_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign percent         = result_q.percent;
	assign charge_low      = result_q.charge_low;
	assign charge_critical = result_q.charge_critical;

`ifndef NO_ASSERTIONS
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.percent <= PCT_FULL))
		else $error("percent above full scale");

	a_flag_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.charge_critical && (crit_thr_q <= low_thr_q)
		|-> result_q.charge_low)
		else $error("critical flag without low flag");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted item lost from input register");

	a_adv_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv_out |=> out_valid_q)
		else $error("result register not filled on advance");
`endif

endmodule

[bench/tb_battery_voltage_to_percent.sv]
// Self-checking bench for battery_voltage_to_percent: random and directed voltages,
// with several threshold settings and random idling on both channels.
// Depends on bvp_pkg for the port types and register codes, and on the RTL top level.
module tb_battery_voltage_to_percent;
	import bvp_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_PCT       = 22;
	localparam int PHASE_ITEMS    = 300;
	localparam int NPHASES        = 6;
	localparam int HOLDOFF_CYCLES = 120;
	localparam int DRAIN_CYCLES   = 4;
	localparam int REPORT_LIMIT   = 10;
	localparam int TIMEOUT_UNITS  = 5_000_000;
	localparam int NKNEE          = 11;

	localparam pct_t LOW_AT_RESET  = 7'd20;
	localparam pct_t CRIT_AT_RESET = 7'd10;

	typedef struct {
		mv_t     voltage;
		result_t reading;
	} due_reading_t;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      in_valid   = 1'b0;
	logic      in_stall;
	mv_t       voltage_mv = '0;
	logic      out_valid;
	logic      out_stall  = 1'b0;
	pct_t      percent;
	logic      charge_low;
	logic      charge_critical;
	logic      cfg_we     = 1'b0;
	cfg_idx_t  cfg_index  = CFG_LOW_THRESHOLD;
	pct_t      cfg_data   = '0;

	// Bench copy of the threshold registers
	pct_t low_thr_model  = LOW_AT_RESET;
	pct_t crit_thr_model = CRIT_AT_RESET;

	mv_t          voltages_to_send [$];
	due_reading_t due_readings [$];

	bit idle_allowed    = 1'b1;
	int holdoff_asked   = 0;
	int holdoff_granted = 0;
	int holdoff_left    = 0;

	int failures         = 0;
	int items_accepted   = 0;
	int results_checked  = 0;
	int settings_applied = 0;

	battery_voltage_to_percent i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.voltage_mv      (voltage_mv),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.percent         (percent),
		.charge_low      (charge_low),
		.charge_critical (charge_critical),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Discharge curve, top point first
	function automatic int knee_mv(int k);
		case (k)
			0:       return 12800;
			1:       return 12650;
			2:       return 12500;
			3:       return 12350;
			4:       return 12200;
			5:       return 12050;
			6:       return 11900;
			7:       return 11750;
			8:       return 11600;
			9:       return 11400;
			default: return 11100;
		endcase
	endfunction

	function automatic int knee_pct(int k);
		return 100 - 10 * k;
	endfunction

	// Interpolate along the curve, truncating within a segment
	function automatic pct_t charge_from_mv(mv_t v);
		int mv;
		int k;
		int span;
		int pct;
		mv = int'(v);
		pct = 0;
		if (mv >= knee_mv(0)) begin
			pct = knee_pct(0);
		end else if (mv > knee_mv(NKNEE - 1)) begin
			for (k = 0; k < NKNEE - 1; k++) begin
				if (mv <= knee_mv(k) && mv > knee_mv(k + 1)) begin
					span = knee_mv(k) - knee_mv(k + 1);
					pct = knee_pct(k + 1)
						+ ((mv - knee_mv(k + 1)) * (knee_pct(k) - knee_pct(k + 1))) / span;
				end
			end
		end
		return pct_t'(pct);
	endfunction

	function automatic result_t predict_reading(mv_t v);
		result_t r;
		r.percent         = charge_from_mv(v);
		r.charge_low      = (r.percent <= low_thr_model);
		r.charge_critical = (r.percent <= crit_thr_model);
		return r;
	endfunction

	// Mostly the sloped region, then the knees, then anything 15 bits allow
	function automatic mv_t random_mv();
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return mv_t'($urandom_range(11050, 12850));
		if (pick < 80) begin
			k = $urandom_range(0, NKNEE - 1);
			return mv_t'(knee_mv(k) + int'($urandom_range(0, 6)) - 3);
		end
		return mv_t'($urandom_range(0, 32767));
	endfunction

	task automatic note_failure(string msg);
		if (failures < REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
		failures++;
	endtask

	task automatic write_reg(cfg_idx_t idx, pct_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LOW_THRESHOLD:  low_thr_model  = val;
			CFG_CRIT_THRESHOLD: crit_thr_model = val;
			default: ;
		endcase
		settings_applied++;
	endtask

	// Hold until every queued item is sent and its result has come back
	task automatic wait_idle();
		while (voltages_to_send.size() > 0 || in_valid || due_readings.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: offer the next voltage, hold it while stalled, log accepted items
	always @(posedge clk) begin : driver
		due_reading_t due;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				due.voltage = voltage_mv;
				due.reading = predict_reading(voltage_mv);
				due_readings.push_back(due);
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (voltages_to_send.size() > 0
					&& !(idle_allowed && $urandom_range(0, 99) < IDLE_PCT)) begin
					in_valid   <= 1'b1;
					voltage_mv <= voltages_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted down on its own
	always @(posedge clk) begin
		if (holdoff_asked != holdoff_granted) begin
			holdoff_granted <= holdoff_asked;
			holdoff_left    <= HOLDOFF_CYCLES;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// Monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : monitor
		due_reading_t due;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_readings.size() == 0) begin
					note_failure($sformatf("unexpected result: percent %0d low %0b critical %0b",
						percent, charge_low, charge_critical));
				end else begin
					due = due_readings.pop_front();
					results_checked++;
					if (percent !== due.reading.percent
						|| charge_low !== due.reading.charge_low
						|| charge_critical !== due.reading.charge_critical)
						note_failure($sformatf(
							"%0d mV: expected %0d%% low %0b crit %0b, got %0d%% low %0b crit %0b",
							due.voltage, due.reading.percent, due.reading.charge_low,
							due.reading.charge_critical, percent, charge_low, charge_critical));
				end
			end
			out_stall <= (holdoff_left > 0) || (idle_allowed && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial begin
		#TIMEOUT_UNITS;
		$display("timeout with %0d results outstanding", due_readings.size());
		$display("battery_voltage_to_percent: mismatch");
		$finish;
	end

	initial begin : stimulus
		int directed [$] = '{0, 1, 11099, 11100, 11101, 11250, 11399, 11400, 11401, 11599,
			11600, 11751, 12049, 12050, 12200, 12349, 12350, 12650, 12799, 12800, 12801,
			20000, 21845, 10922, 32767};
		int phase;
		int n;
		pct_t lo_thr;
		pct_t crit_thr;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Curve ends, most knees with some of their neighbours, at the reset thresholds
		foreach (directed[i])
			voltages_to_send.push_back(mv_t'(directed[i]));
		wait_idle();

		for (phase = 0; phase < NPHASES; phase++) begin
			case (phase)
				0: begin lo_thr = 7'd0;   crit_thr = 7'd0;   end
				1: begin lo_thr = 7'd100; crit_thr = 7'd100; end
				2: begin lo_thr = 7'd127; crit_thr = 7'd0;   end
				3: begin lo_thr = 7'd0;   crit_thr = 7'd127; end
				4: begin lo_thr = 7'd101; crit_thr = 7'd55;  end
				default: begin
					lo_thr   = pct_t'($urandom_range(0, 127));
					crit_thr = pct_t'($urandom_range(0, 127));
				end
			endcase
			write_reg(CFG_LOW_THRESHOLD, lo_thr);
			write_reg(CFG_CRIT_THRESHOLD, crit_thr);

			// One phase runs flat out; another backs the block up behind a long stall
			idle_allowed = (phase != 1);
			for (n = 0; n < PHASE_ITEMS; n++)
				voltages_to_send.push_back(random_mv());
			if (phase == 2)
				holdoff_asked++;
			wait_idle();
			idle_allowed = 1'b1;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_readings.size() > 0)
			note_failure($sformatf("%0d results never arrived", due_readings.size()));

		$display("summary: %0d voltages converted and %0d results checked", items_accepted,
			results_checked);
		$display("summary: %0d register writes over %0d threshold settings", settings_applied,
			NPHASES);
		if (failures == 0) begin
			$display("battery_voltage_to_percent: match");
		end else begin
			$display("%0d failures", failures);
			$display("battery_voltage_to_percent: mismatch");
		end
		$finish;
	end

endmodule
